FILE: src/ehvp_pkg.sv
// ----------------------------------------------------------------------------
// ehvp_pkg: shared definitions for the ethernet header / vlan parser
// Holds the frame constants, the tag and ethertype codes, the beat and result
// records and the helper functions that classify an ethertype.
// ----------------------------------------------------------------------------
package ehvp_pkg;

    // frame geometry
    localparam int MAX_FRAME_BYTES = 16384;
    localparam int MAX_VLAN_TAGS   = 2;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PLEN_W          = 14;
    localparam int ETH_HDR_BYTES   = 14;
    localparam int TAG_BYTES       = 4;
    localparam int DST_END         = 6;
    localparam int SRC_END         = 12;

    // tag protocol identifiers
    localparam logic [15:0] TPID_8021Q  = 16'h8100;
    localparam logic [15:0] TPID_8021AD = 16'h88A8;
    localparam logic [15:0] TPID_LEGACY = 16'h9100;

    // known ethertypes
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_RARP = 16'h8035;

    localparam logic [15:0] VLAN_ID_MASK = 16'h0FFF;

    typedef enum logic [2:0] {
        PC_IPV4        = 3'd0,
        PC_IPV6        = 3'd1,
        PC_ARP         = 3'd2,
        PC_RARP        = 3'd3,
        PC_UNSUPPORTED = 3'd4
    } payload_class_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TRUNC_FRAME = 2'd1,
        ST_TRUNC_TAG   = 2'd2
    } status_t;

    // one frame byte as it enters the parser
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } frame_beat_t;

    // one parsed header
    typedef struct packed {
        logic [47:0]       dst_mac;
        logic [47:0]       src_mac;
        logic [1:0]        tag_count;
        logic [11:0]       outer_vlan_id;
        logic [11:0]       inner_vlan_id;
        logic [15:0]       ether_type;
        payload_class_t    payload_class;
        logic [4:0]        payload_offset;
        logic [PLEN_W-1:0] payload_length;
        logic [LEN_W-1:0]  frame_length;
        status_t           status;
    } header_result_t;

    function automatic logic is_tpid(input logic [15:0] etype);
        return (etype == TPID_8021Q) || (etype == TPID_8021AD) || (etype == TPID_LEGACY);
    endfunction

    function automatic payload_class_t class_of(input logic [15:0] etype);
        payload_class_t cls;
        unique case (etype)
            ETYPE_IPV4: cls = PC_IPV4;
            ETYPE_IPV6: cls = PC_IPV6;
            ETYPE_ARP:  cls = PC_ARP;
            ETYPE_RARP: cls = PC_RARP;
            default:    cls = PC_UNSUPPORTED;
        endcase
        return cls;
    endfunction

endpackage

FILE: src/ehvp_in_if.sv
// ----------------------------------------------------------------------------
// ehvp_in_if: byte stream channel
// Carries one frame byte and its end-of-frame flag with a valid/ready pair.
// ----------------------------------------------------------------------------
interface ehvp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

FILE: src/ehvp_out_if.sv
// ----------------------------------------------------------------------------
// ehvp_out_if: parsed header channel
// Carries one parsed header record per frame with a valid/ready pair.
// ----------------------------------------------------------------------------
interface ehvp_out_if;

    logic        valid;
    logic        ready;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [1:0]  tag_count;
    logic [11:0] outer_vlan_id;
    logic [11:0] inner_vlan_id;
    logic [15:0] ether_type;
    logic [2:0]  payload_class;
    logic [4:0]  payload_offset;
    logic [13:0] payload_length;
    logic [14:0] frame_length;
    logic [1:0]  status;

    modport source (
        output valid, output dst_mac, output src_mac, output tag_count,
        output outer_vlan_id, output inner_vlan_id, output ether_type,
        output payload_class, output payload_offset, output payload_length,
        output frame_length, output status, input ready
    );
    modport sink (
        input valid, input dst_mac, input src_mac, input tag_count,
        input outer_vlan_id, input inner_vlan_id, input ether_type,
        input payload_class, input payload_offset, input payload_length,
        input frame_length, input status, output ready
    );

endinterface

FILE: src/ehvp_hdr_capture.sv
// ----------------------------------------------------------------------------
// ehvp_hdr_capture: per-frame header state
// Captures MACs, ethertype and vlan tags byte by byte and forms the parsed
// header record on the last byte of a frame, then clears for the next frame.
// ----------------------------------------------------------------------------
module ehvp_hdr_capture (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           beat_fire,
    input  ehvp_pkg::frame_beat_t          beat,
    output ehvp_pkg::header_result_t       result
);

    localparam int LW = ehvp_pkg::LEN_W;

    logic [LW-1:0] pos_reg,   pos_next;
    logic [47:0]   dst_reg,   dst_next;
    logic [47:0]   src_reg,   src_next;
    logic [15:0]   type_reg,  type_next;
    logic [15:0]   tci_reg,   tci_next;
    logic [1:0]    tags_reg,  tags_next;
    logic [11:0]   vlan0_reg, vlan0_next;
    logic [11:0]   vlan1_reg, vlan1_next;
    logic          done_reg,  done_next;

    // values after this byte, before the end-of-frame clear
    logic [LW-1:0] pos_upd;
    logic [47:0]   dst_upd;
    logic [47:0]   src_upd;
    logic [15:0]   type_upd;
    logic [15:0]   tci_upd;
    logic [1:0]    tags_upd;
    logic [11:0]   vlan0_upd;
    logic [11:0]   vlan1_upd;
    logic          done_upd;

    logic [7:0]    b;
    logic [5:0]    dst_sh;
    logic [5:0]    src_sh;
    logic [3:0]    src_idx;
    logic [1:0]    rel;
    logic [15:0]   type_shifted;
    logic [4:0]    offset;
    logic [1:0]    tags_out;

    // byte capture
    always_comb
    begin
        b            = beat.data_byte;
        dst_sh       = {3'(3'd5 - pos_reg[2:0]), 3'b000};
        src_idx      = 4'd11 - pos_reg[3:0];
        src_sh       = {src_idx[2:0], 3'b000};
        rel          = pos_reg[1:0] + 2'd2;
        type_shifted = {type_reg[7:0], b};

        pos_upd   = (pos_reg < LW'(ehvp_pkg::MAX_FRAME_BYTES)) ? pos_reg + LW'(1) : pos_reg;
        dst_upd   = dst_reg;
        src_upd   = src_reg;
        type_upd  = type_reg;
        tci_upd   = tci_reg;
        tags_upd  = tags_reg;
        vlan0_upd = vlan0_reg;
        vlan1_upd = vlan1_reg;
        done_upd  = done_reg;

        priority if (pos_reg < LW'(ehvp_pkg::DST_END))
        begin
            dst_upd = dst_reg | ({40'b0, b} << dst_sh);
        end
        else if (pos_reg < LW'(ehvp_pkg::SRC_END))
        begin
            src_upd = src_reg | ({40'b0, b} << src_sh);
        end
        else if (pos_reg < LW'(ehvp_pkg::ETH_HDR_BYTES))
        begin
            type_upd = type_shifted;
            if (pos_reg == LW'(ehvp_pkg::ETH_HDR_BYTES - 1))
            begin
                done_upd = !(ehvp_pkg::is_tpid(type_shifted) &&
                             (tags_reg < 2'(ehvp_pkg::MAX_VLAN_TAGS)));
            end
        end
        else if (!done_reg)
        begin
            if (!rel[1])
            begin
                tci_upd = {tci_reg[7:0], b};
            end
            else
            begin
                type_upd = type_shifted;
                if (rel[0])
                begin
                    if (tags_reg[0])
                    begin
                        vlan1_upd = tci_reg[11:0];
                    end
                    else
                    begin
                        vlan0_upd = tci_reg[11:0];
                    end
                    tags_upd = tags_reg + 2'd1;
                    done_upd = !(ehvp_pkg::is_tpid(type_shifted) &&
                                 (tags_upd < 2'(ehvp_pkg::MAX_VLAN_TAGS)));
                end
            end
        end
        else
        begin
            // payload byte: only the byte count moves
        end
    end

    // result record from the updated state
    always_comb
    begin
        tags_out = tags_upd;
        offset   = 5'(ehvp_pkg::ETH_HDR_BYTES) + {1'b0, tags_upd, 2'b00};

        result.dst_mac        = dst_upd;
        result.src_mac        = src_upd;
        result.frame_length   = pos_upd;
        result.ether_type     = 16'h0000;
        result.payload_class  = ehvp_pkg::PC_UNSUPPORTED;
        result.payload_length = '0;

        priority if (pos_upd < LW'(ehvp_pkg::ETH_HDR_BYTES))
        begin
            result.status = ehvp_pkg::ST_TRUNC_FRAME;
            tags_out      = 2'd0;
            offset        = 5'(ehvp_pkg::ETH_HDR_BYTES);
        end
        else if (!done_upd)
        begin
            result.status = ehvp_pkg::ST_TRUNC_TAG;
        end
        else
        begin
            result.status         = ehvp_pkg::ST_OK;
            result.ether_type     = type_upd;
            result.payload_class  = ehvp_pkg::class_of(type_upd);
            result.payload_length = ehvp_pkg::PLEN_W'(pos_upd - LW'(offset));
        end

        result.tag_count      = tags_out;
        result.payload_offset = offset;
        result.outer_vlan_id  = (tags_out >= 2'd1) ? vlan0_upd : 12'd0;
        result.inner_vlan_id  = (tags_out >= 2'd2) ? vlan1_upd : 12'd0;
    end

    // clear on the last byte for the next frame
    always_comb
    begin
        if (beat.last_byte)
        begin
            pos_next   = '0;
            dst_next   = '0;
            src_next   = '0;
            type_next  = '0;
            tci_next   = '0;
            tags_next  = '0;
            vlan0_next = '0;
            vlan1_next = '0;
            done_next  = 1'b0;
        end
        else
        begin
            pos_next   = pos_upd;
            dst_next   = dst_upd;
            src_next   = src_upd;
            type_next  = type_upd;
            tci_next   = tci_upd;
            tags_next  = tags_upd;
            vlan0_next = vlan0_upd;
            vlan1_next = vlan1_upd;
            done_next  = done_upd;
        end
    end

    // header state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            dst_reg   <= '0;
            src_reg   <= '0;
            type_reg  <= '0;
            tci_reg   <= '0;
            tags_reg  <= '0;
            vlan0_reg <= '0;
            vlan1_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (beat_fire)
        begin
            pos_reg   <= pos_next;
            dst_reg   <= dst_next;
            src_reg   <= src_next;
            type_reg  <= type_next;
            tci_reg   <= tci_next;
            tags_reg  <= tags_next;
            vlan0_reg <= vlan0_next;
            vlan1_reg <= vlan1_next;
            done_reg  <= done_next;
        end
    end

endmodule

FILE: src/ethernet_header_vlan_parser_top.sv
// ----------------------------------------------------------------------------
// ethernet_header_vlan_parser_top: ethernet II header parser with q-in-q tags
// The result register takes the header record as the last byte leaves the
// byte register. Throughput: one byte per cycle while no last byte waits for
// a free output. Frames may follow each other with no gap while the output
// drains. Reset: rst_n clears the byte valid, header state and output valid.
// ----------------------------------------------------------------------------
module ethernet_header_vlan_parser_top (
    input  logic clk,
    input  logic rst_n,
    ehvp_in_if.sink    frame_in,
    ehvp_out_if.source header_out
);

    logic                     s1_valid_reg;
    ehvp_pkg::frame_beat_t    s1_beat_reg;
    logic                     out_valid_reg;
    ehvp_pkg::header_result_t out_res_reg;

    logic                     out_free;
    logic                     fire;
    logic                     in_fire;
    ehvp_pkg::header_result_t result;

    // handshake: a non-last byte always proceeds, a last byte needs a free output
    assign out_free       = !out_valid_reg || header_out.ready;
    assign fire           = s1_valid_reg && (!s1_beat_reg.last_byte || out_free);
    assign frame_in.ready = !s1_valid_reg || fire;
    assign in_fire        = frame_in.valid && frame_in.ready;

    // input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame_in.ready)
        begin
            s1_valid_reg <= frame_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_beat_reg.data_byte <= frame_in.data_byte;
            s1_beat_reg.last_byte <= frame_in.last_byte;
        end
    end

    ehvp_hdr_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_fire (fire),
        .beat      (s1_beat_reg),
        .result    (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && s1_beat_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (header_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s1_beat_reg.last_byte)
        begin
            out_res_reg <= result;
        end
    end

    // output channel
    assign header_out.valid          = out_valid_reg;
    assign header_out.dst_mac        = out_res_reg.dst_mac;
    assign header_out.src_mac        = out_res_reg.src_mac;
    assign header_out.tag_count      = out_res_reg.tag_count;
    assign header_out.outer_vlan_id  = out_res_reg.outer_vlan_id;
    assign header_out.inner_vlan_id  = out_res_reg.inner_vlan_id;
    assign header_out.ether_type     = out_res_reg.ether_type;
    assign header_out.payload_class  = out_res_reg.payload_class;
    assign header_out.payload_offset = out_res_reg.payload_offset;
    assign header_out.payload_length = out_res_reg.payload_length;
    assign header_out.frame_length   = out_res_reg.frame_length;
    assign header_out.status         = out_res_reg.status;

endmodule
